FILE: sv/fdc_pkg.sv
// Shared types and constants of the freezer defrost controller.
package fdc_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned TempW  = 10;
  localparam int unsigned WaitW  = 10;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  typedef enum logic [1:0] {
    MODE_COOL    = 2'd0,
    MODE_DEFROST = 2'd1,
    MODE_WAIT    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_COOL_PERIOD   = 3'd0,
    REG_DEFROST_PERIOD = 3'd1,
    REG_COMP_ON_ABOVE = 3'd2,
    REG_COMP_OFF_BELOW = 3'd3,
    REG_DEFROST_END   = 3'd4,
    REG_POST_WAIT     = 3'd5
  } reg_idx_t;

  localparam logic [CountW-1:0] COOL_PERIOD_RST    = 16'd28800;
  localparam logic [CountW-1:0] DEFROST_PERIOD_RST = 16'd1500;
  localparam logic signed [TempW-1:0] COMP_ON_RST  = -10'sd100;
  localparam logic signed [TempW-1:0] COMP_OFF_RST = -10'sd200;
  localparam logic signed [TempW-1:0] DEFROST_END_RST = 10'sd100;
  localparam logic [WaitW-1:0] POST_WAIT_RST       = 10'd100;

  typedef struct packed {
    logic [CountW-1:0]        cool_period;
    logic [CountW-1:0]        defrost_period;
    logic signed [TempW-1:0]  comp_on_above;
    logic signed [TempW-1:0]  comp_off_below;
    logic signed [TempW-1:0]  defrost_end_above;
    logic [WaitW-1:0]         post_wait;
  } cfg_t;

  typedef struct packed {
    logic  compressor_on;
    logic  fan_on;
    logic  heater_on;
    mode_t mode;
  } res_t;

endpackage

FILE: sv/freezer_defrost_controller_unit.sv
// Top level of the freezer defrost controller: channel registers around the core.
//
// Each input item is a one-second tick (in_cmd low) or a temperature sample in
// signed tenths of a degree (in_cmd high). Every item gives exactly one result
// item carrying the compressor, fan and heater drives and the current mode.
// An item is taken when in_valid is high and in_stall is low; a result is taken
// when out_valid is high and out_stall is low.
// An accepted item is held in the input register, its state update and
// result are worked out in a single pass of logic, and the result is then
// registered on the output register. One item per cycle is sustained while
// the receiver does not stall.
// When the receiver stalls, the result holds on the output register and one
// more item may wait in the input register; in_stall rises only while both
// are full and out_stall is high.
// Synchronous reset clears all counters and flags, empties both registers and
// loads the configuration defaults. Configuration is to be written through
// the APB-style port while no item is in flight; the block does not enforce it.
module freezer_defrost_controller_unit
  import fdc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_cmd,
  input  logic signed [TempW-1:0] in_temperature_tenths,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_compressor_on,
  output logic                    out_fan_on,
  output logic                    out_heater_on,
  output logic [1:0]              out_mode,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrW-1:0]        paddr,
  input  logic [DataW-1:0]        pwdata,
  output logic [DataW-1:0]        prdata,
  output logic                    pready
);

  cfg_t                    cfg;
  res_t                    res;
  res_t                    out_res_r;
  logic                    in_valid_r, in_valid_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    in_cmd_r;
  logic signed [TempW-1:0] in_temp_r;
  logic                    advance;
  logic                    accept;

  fdc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fdc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .cmd   (in_cmd_r),
    .temp  (in_temp_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd_r  <= in_cmd;
      in_temp_r <= in_temperature_tenths;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_compressor_on = out_res_r.compressor_on;
  assign out_fan_on        = out_res_r.fan_on;
  assign out_heater_on     = out_res_r.heater_on;
  assign out_mode          = out_res_r.mode;

endmodule

FILE: sv/fdc_cfg_regs.sv
// Configuration register file behind the APB-style port.
module fdc_cfg_regs
  import fdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_COOL_PERIOD:    cfg_nxt.cool_period       = pwdata[CountW-1:0];
        REG_DEFROST_PERIOD: cfg_nxt.defrost_period    = pwdata[CountW-1:0];
        REG_COMP_ON_ABOVE:  cfg_nxt.comp_on_above     = pwdata[TempW-1:0];
        REG_COMP_OFF_BELOW: cfg_nxt.comp_off_below    = pwdata[TempW-1:0];
        REG_DEFROST_END:    cfg_nxt.defrost_end_above = pwdata[TempW-1:0];
        REG_POST_WAIT:      cfg_nxt.post_wait         = pwdata[WaitW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cool_period       <= COOL_PERIOD_RST;
      cfg_r.defrost_period    <= DEFROST_PERIOD_RST;
      cfg_r.comp_on_above     <= COMP_ON_RST;
      cfg_r.comp_off_below    <= COMP_OFF_RST;
      cfg_r.defrost_end_above <= DEFROST_END_RST;
      cfg_r.post_wait         <= POST_WAIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Signed thresholds read back sign-extended.
  always_comb begin
    unique case (idx)
      REG_COOL_PERIOD:    prdata = {{(DataW-CountW){1'b0}}, cfg_r.cool_period};
      REG_DEFROST_PERIOD: prdata = {{(DataW-CountW){1'b0}}, cfg_r.defrost_period};
      REG_COMP_ON_ABOVE:  prdata = {{(DataW-TempW){cfg_r.comp_on_above[TempW-1]}},
                                    cfg_r.comp_on_above};
      REG_COMP_OFF_BELOW: prdata = {{(DataW-TempW){cfg_r.comp_off_below[TempW-1]}},
                                    cfg_r.comp_off_below};
      REG_DEFROST_END:    prdata = {{(DataW-TempW){cfg_r.defrost_end_above[TempW-1]}},
                                    cfg_r.defrost_end_above};
      REG_POST_WAIT:      prdata = {{(DataW-WaitW){1'b0}}, cfg_r.post_wait};
      default:            prdata = '0;
    endcase
  end

endmodule

FILE: sv/fdc_core.sv
// Controller state and the per-item update of timer, defrost and thermostat.
module fdc_core
  import fdc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic                    cmd,
  input  logic signed [TempW-1:0] temp,
  input  cfg_t                    cfg,
  output res_t                    res
);

  logic [CountW-1:0] second_count_r, second_count_nxt;
  logic              defrost_due_r, defrost_due_nxt;
  logic              period_is_defrost_r, period_is_defrost_nxt;
  logic [WaitW-1:0]  wait_count_r, wait_count_nxt;
  logic              compressor_state_r, compressor_state_nxt;
  logic [CountW-1:0] period;
  logic [CountW-1:0] count_inc;

  assign period    = period_is_defrost_r ? cfg.defrost_period : cfg.cool_period;
  assign count_inc = second_count_r + 1'b1;

  always_comb begin
    second_count_nxt      = second_count_r;
    defrost_due_nxt       = defrost_due_r;
    period_is_defrost_nxt = period_is_defrost_r;
    wait_count_nxt        = wait_count_r;
    compressor_state_nxt  = compressor_state_r;
    if (!cmd) begin
      second_count_nxt = count_inc;
      if (count_inc == period) begin
        second_count_nxt = '0;
        if (!defrost_due_r) begin
          defrost_due_nxt       = 1'b1;
          period_is_defrost_nxt = 1'b1;
          wait_count_nxt        = '0;
          compressor_state_nxt  = 1'b0;
        end else begin
          defrost_due_nxt       = 1'b0;
          period_is_defrost_nxt = 1'b0;
          wait_count_nxt        = cfg.post_wait;
        end
      end else if (!defrost_due_r && (wait_count_r != '0)) begin
        wait_count_nxt = wait_count_r - 1'b1;
      end
    end else begin
      if (defrost_due_r) begin
        // Early end of defrost keeps the second counter running.
        if (temp > cfg.defrost_end_above) begin
          defrost_due_nxt       = 1'b0;
          period_is_defrost_nxt = 1'b0;
          wait_count_nxt        = cfg.post_wait;
        end
      end else if (wait_count_r == '0) begin
        // The off threshold is checked last so that it wins when crossed.
        if (temp > cfg.comp_on_above) begin
          compressor_state_nxt = 1'b1;
        end
        if (temp < cfg.comp_off_below) begin
          compressor_state_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (defrost_due_nxt) begin
      res.mode = MODE_DEFROST;
    end else if (wait_count_nxt != '0) begin
      res.mode = MODE_WAIT;
    end else begin
      res.mode = MODE_COOL;
    end
    res.fan_on        = (res.mode == MODE_COOL);
    res.heater_on     = (res.mode == MODE_DEFROST);
    res.compressor_on = (res.mode == MODE_COOL) && compressor_state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_count_r      <= '0;
      defrost_due_r       <= 1'b0;
      period_is_defrost_r <= 1'b0;
      wait_count_r        <= '0;
      compressor_state_r  <= 1'b0;
    end else if (step) begin
      second_count_r      <= second_count_nxt;
      defrost_due_r       <= defrost_due_nxt;
      period_is_defrost_r <= period_is_defrost_nxt;
      wait_count_r        <= wait_count_nxt;
      compressor_state_r  <= compressor_state_nxt;
    end
  end

endmodule

FILE: sv/fdc_checker.sv
// Port-level checks of the freezer defrost controller and their binding.
module fdc_checker
  import fdc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_compressor_on,
  input logic       out_fan_on,
  input logic       out_heater_on,
  input logic [1:0] out_mode
);

  // A result waiting under stall keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mode)
      && $stable(out_compressor_on) && $stable(out_fan_on) && $stable(out_heater_on))
    else $error("result changed while stalled");

  // Drives must agree with the mode: fan and compressor only in cooling, heater only in defrost.
  a_drive_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fan_on == (out_mode == MODE_COOL))
      && (out_heater_on == (out_mode == MODE_DEFROST))
      && (!out_compressor_on || out_mode == MODE_COOL))
    else $error("outputs disagree with mode");

  // With the output register empty the input side can never be held off.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output empty");

  // An item taken into an empty block shows its result after passing the input and output registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid && !in_stall ##1 !out_valid |=> out_valid)
    else $error("result missing after accepted item");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind freezer_defrost_controller_unit fdc_checker u_fdc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_compressor_on (out_compressor_on),
  .out_fan_on        (out_fan_on),
  .out_heater_on     (out_heater_on),
  .out_mode          (out_mode)
);

FILE: sim/freezer_defrost_controller_unit_tb.sv
// Self-checking testbench for the freezer defrost controller: directed table, zero-period run, random phases.
`timescale 1ns / 100ps

module freezer_defrost_controller_unit_tb;
  import fdc_pkg::*;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam int RANDOM_ITEMS      = 1050;
  localparam int CALM_TAIL         = 160;
  localparam int QUIET_LIMIT       = 2000;
  localparam int ZERO_PERIOD_TICKS = 40;
  localparam int MAX_PRINTED       = 30;
  localparam int N_DIRECTED        = 35;

  typedef struct packed {
    logic                    is_cfg;
    reg_idx_t                idx;
    logic [DataW-1:0]        val;
    logic                    cmd;
    logic signed [TempW-1:0] temp;
    logic                    typed;
    res_t                    want;
  } plan_row_t;

  localparam res_t R_NONE     = '{1'b0, 1'b0, 1'b0, MODE_COOL};
  localparam res_t R_COOL_OFF = '{1'b0, 1'b1, 1'b0, MODE_COOL};
  localparam res_t R_COOL_ON  = '{1'b1, 1'b1, 1'b0, MODE_COOL};

  // Short hand-made sequence: reset defaults first, then tiny periods so that defrost,
  // the post-defrost hold, early end, zero hold and crossed thresholds all come up.
  localparam plan_row_t DIRECTED [0:N_DIRECTED-1] = '{
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_TICK, 10'sd0, 1'b1, R_COOL_OFF},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_SAMPLE, 10'sd500, 1'b1, R_COOL_ON},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_SAMPLE, -10'sd500, 1'b1, R_COOL_OFF},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_SAMPLE, -10'sd100, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_SAMPLE, -10'sd200, 1'b0, R_NONE},
    '{1'b1, REG_COOL_PERIOD, 32'd4, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b1, REG_DEFROST_PERIOD, 32'd3, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b1, REG_POST_WAIT, 32'd2, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_SAMPLE, 10'sd0, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_SAMPLE, 10'sd100, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_SAMPLE, 10'sd500, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b1, REG_POST_WAIT, 32'd0, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b1, REG_DEFROST_END, -32'sd500, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b1, REG_COOL_PERIOD, 32'd3, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_SAMPLE, -10'sd499, 1'b0, R_NONE},
    '{1'b1, REG_COMP_ON_ABOVE, 32'd0, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b1, REG_COMP_OFF_BELOW, 32'd100, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_SAMPLE, 10'sd50, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_SAMPLE, 10'sd200, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_SAMPLE, -10'sd1, 1'b0, R_NONE},
    '{1'b1, REG_COMP_ON_ABOVE, 32'd500, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b1, REG_COMP_OFF_BELOW, -32'sd500, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b1, REG_DEFROST_END, 32'd500, CMD_TICK, 10'sd0, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_SAMPLE, 10'sd500, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_SAMPLE, -10'sd500, 1'b0, R_NONE},
    '{1'b0, REG_COOL_PERIOD, 32'd0, CMD_SAMPLE, 10'sd499, 1'b0, R_NONE}
  };

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_cmd;
  logic signed [TempW-1:0] in_temperature_tenths;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_compressor_on;
  logic                    out_fan_on;
  logic                    out_heater_on;
  logic [1:0]              out_mode;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [AddrW-1:0]        paddr;
  logic [DataW-1:0]        pwdata;
  logic [DataW-1:0]        prdata;
  logic                    pready;

  // Own copy of the controller's settings and state.
  logic [CountW-1:0]       cool_per;
  logic [CountW-1:0]       defrost_per;
  logic signed [TempW-1:0] on_above;
  logic signed [TempW-1:0] off_below;
  logic signed [TempW-1:0] end_above;
  logic [WaitW-1:0]        hold_ticks;
  logic [CountW-1:0]       sec_cnt;
  logic                    defrost_due_q;
  logic                    period_defrost_q;
  logic [WaitW-1:0]        hold_cnt;
  logic                    comp_q;

  res_t expected_drives [$];
  res_t front_drive;
  logic idle_on;
  int   mismatches;
  int   n_checked;
  int   n_ticks;
  int   n_samples;
  int   n_phases;
  int   n_defrosts;
  int   n_early_ends;
  int   quiet_cycles;

  freezer_defrost_controller_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_cmd                (in_cmd),
    .in_temperature_tenths (in_temperature_tenths),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_compressor_on     (out_compressor_on),
    .out_fan_on            (out_fan_on),
    .out_heater_on         (out_heater_on),
    .out_mode              (out_mode),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void finish_defrost();
    defrost_due_q    = 1'b0;
    period_defrost_q = 1'b0;
    hold_cnt         = hold_ticks;
  endfunction

  // Applies one item to the local state and returns the drives it leads to.
  function automatic res_t advance_freezer(input logic cmd, input logic signed [TempW-1:0] t);
    logic [CountW-1:0] period;
    res_t              r;
    period = period_defrost_q ? defrost_per : cool_per;
    if (cmd == CMD_TICK) begin
      sec_cnt = sec_cnt + 1'b1;
      if (sec_cnt == period) begin
        sec_cnt = '0;
        if (!defrost_due_q) begin
          defrost_due_q    = 1'b1;
          period_defrost_q = 1'b1;
          hold_cnt         = '0;
          comp_q           = 1'b0;
          n_defrosts++;
        end else begin
          finish_defrost();
        end
      end else if (!defrost_due_q && hold_cnt != '0) begin
        hold_cnt = hold_cnt - 1'b1;
      end
    end else if (defrost_due_q) begin
      if (t > end_above) begin
        finish_defrost();
        n_early_ends++;
      end
    end else if (hold_cnt == '0) begin
      // The off compare comes last, so it wins when the thresholds cross.
      if (t > on_above) comp_q = 1'b1;
      if (t < off_below) comp_q = 1'b0;
    end
    if (defrost_due_q) begin
      r.mode = MODE_DEFROST;
    end else if (hold_cnt != '0) begin
      r.mode = MODE_WAIT;
    end else begin
      r.mode = MODE_COOL;
    end
    r.compressor_on = (r.mode == MODE_COOL) && comp_q;
    r.fan_on        = (r.mode == MODE_COOL);
    r.heater_on     = (r.mode == MODE_DEFROST);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [1:0] got, input logic [1:0] want);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  task automatic send_item(input logic cmd, input logic signed [TempW-1:0] temp,
                           input logic typed, input res_t want);
    res_t predicted;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_cmd                <= cmd;
    in_temperature_tenths <= temp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_freezer(cmd, temp);
    expected_drives.push_back(typed ? want : predicted);
    if (cmd == CMD_TICK) n_ticks++;
    else n_samples++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [DataW-1:0] v);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_COOL_PERIOD:    cool_per    = v[CountW-1:0];
      REG_DEFROST_PERIOD: defrost_per = v[CountW-1:0];
      REG_COMP_ON_ABOVE:  on_above    = v[TempW-1:0];
      REG_COMP_OFF_BELOW: off_below   = v[TempW-1:0];
      REG_DEFROST_END:    end_above   = v[TempW-1:0];
      REG_POST_WAIT:      hold_ticks  = v[WaitW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [DataW-1:0] pick_threshold();
    case ($urandom_range(0, 7))
      0:       return -32'sd500;
      1:       return 32'sd500;
      default: return DataW'(int'($urandom_range(0, 1000)) - 500);
    endcase
  endfunction

  // Receiver side: random stall bursts.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_drives.size() == 0) begin
        report_mismatch("result item with none expected", 2'd0, 2'd0);
      end else begin
        front_drive = expected_drives.pop_front();
        n_checked++;
        if (out_compressor_on !== front_drive.compressor_on)
          report_mismatch("compressor_on", out_compressor_on, front_drive.compressor_on);
        if (out_fan_on !== front_drive.fan_on)
          report_mismatch("fan_on", out_fan_on, front_drive.fan_on);
        if (out_heater_on !== front_drive.heater_on)
          report_mismatch("heater_on", out_heater_on, front_drive.heater_on);
        if (out_mode !== front_drive.mode)
          report_mismatch("mode", out_mode, front_drive.mode);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $realtime, QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    plan_row_t         row;
    int                i;
    int                k;
    int                n;
    int                tv;
    int                tick_pct;
    int                items_done;
    int                dp_lo;
    int                dp;
    int                cp_lo;
    int                cp;
    logic              cmd;

    rst_n                 <= 1'b0;
    in_valid              <= 1'b0;
    in_cmd                <= CMD_TICK;
    in_temperature_tenths <= '0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    idle_on          = 1'b1;
    mismatches       = 0;
    n_checked        = 0;
    n_ticks          = 0;
    n_samples        = 0;
    n_phases         = 0;
    n_defrosts       = 0;
    n_early_ends     = 0;
    quiet_cycles     = 0;
    cool_per         = COOL_PERIOD_RST;
    defrost_per      = DEFROST_PERIOD_RST;
    on_above         = COMP_ON_RST;
    off_below        = COMP_OFF_RST;
    end_above        = DEFROST_END_RST;
    hold_ticks       = POST_WAIT_RST;
    sec_cnt          = '0;
    defrost_due_q    = 1'b0;
    period_defrost_q = 1'b0;
    hold_cnt         = '0;
    comp_q           = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.is_cfg) write_register(row.idx, row.val);
      else send_item(row.cmd, row.temp, row.typed, row.want);
    end

    // Zero cooling period: the count climbs straight past it without a match.
    idle_on = 1'b0;
    write_register(REG_COOL_PERIOD, 32'd0);
    write_register(REG_DEFROST_PERIOD, 32'd65535);
    write_register(REG_DEFROST_END, 32'd0);
    for (k = 0; k < ZERO_PERIOD_TICKS; k++) begin
      send_item(CMD_TICK, TempW'(k), 1'b0, R_NONE);
    end
    send_item(CMD_SAMPLE, 10'sd500, 1'b0, R_NONE);
    idle_on = 1'b1;
    n_phases = 1;

    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      if (items_done >= RANDOM_ITEMS - CALM_TAIL) idle_on = 1'b0;
      drain_results();
      // Keep the count below the live period, and the cooling period at least as long as
      // the defrost one, so that an early defrost end never leaves the count past it.
      dp_lo = period_defrost_q ? int'(sec_cnt) + 1 : 1;
      dp = ($urandom_range(0, 14) == 0) ? 65535 : dp_lo + int'($urandom_range(0, 15));
      cp_lo = (dp > int'(sec_cnt) + 1) ? dp : int'(sec_cnt) + 1;
      cp = ($urandom_range(0, 14) == 0) ? 65535 : cp_lo + int'($urandom_range(0, 20));
      if (cp > 65535) cp = 65535;
      write_register(REG_COOL_PERIOD, DataW'(cp));
      write_register(REG_DEFROST_PERIOD, DataW'(dp));
      write_register(REG_COMP_ON_ABOVE, pick_threshold());
      write_register(REG_COMP_OFF_BELOW, pick_threshold());
      write_register(REG_DEFROST_END, pick_threshold());
      if (n_phases == 2) write_register(REG_POST_WAIT, 32'd1023);
      else write_register(REG_POST_WAIT, DataW'($urandom_range(0, 6)));
      n = $urandom_range(60, 120);
      tick_pct = $urandom_range(35, 80);
      for (k = 0; k < n; k++) begin
        cmd = (int'($urandom_range(0, 99)) < tick_pct) ? CMD_TICK : CMD_SAMPLE;
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 2))
            0:       tv = on_above;
            1:       tv = off_below;
            default: tv = end_above;
          endcase
          tv = tv + int'($urandom_range(0, 2)) - 1;
          if (tv > 500) tv = 500;
          if (tv < -500) tv = -500;
        end else begin
          tv = int'($urandom_range(0, 1000)) - 500;
        end
        send_item(cmd, tv[TempW-1:0], 1'b0, R_NONE);
      end
      items_done += n;
      n_phases++;
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("Sent %0d ticks and %0d samples under %0d register settings.",
             n_ticks, n_samples, n_phases);
    $display("Saw %0d defrost periods, %0d ended early; %0d result items checked.",
             n_defrosts, n_early_ends, n_checked);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
